// ----- rtl/core/lsch_pkg.sv -----
// Shared types, widths and codes of the lottery scheduler.
package lsch_pkg;

	localparam int DEF_SLOTS = 64;

	localparam int CMD_W  = 2;
	localparam int SLOT_W = 6;
	localparam int TICK_W = 16;
	localparam int WIN_W  = 32;
	localparam int RND_W  = 32;
	localparam int STAT_W = 2;

	localparam int IN_DATA_W  = 56;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 56;
	localparam int OUT_USER_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_TICKETS = 2'd0,
		CMD_SET_FLAGS   = 2'd1,
		CMD_DRAW        = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_REJECT = 2'd1,
		STAT_NONE   = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_DIV,
		S_WALK,
		S_DONE
	} state_t;

	// One slot entry as it is kept in the table memory.
	typedef struct packed {
		logic [WIN_W-1:0]  win;
		logic [TICK_W-1:0] tickets;
		logic              in_use;
		logic              runnable;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		stat_t              status;
		logic [SLOT_W-1:0]  slot;
		logic [TICK_W-1:0]  tickets;
		logic               in_use;
		logic [WIN_W-1:0]   win;
	} res_t;

	// Status of the modulo unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/lottery_scheduler.sv -----
// Top level of the lottery scheduler: command sequencer around the slot table memory.
//
//  Channel | Direction | tdata (low bit up)                               | tuser
//  s_*     | in        | slot, ticket_value, in_use_value, runnable_value, | cmd
//          |           | random_word                                      |
//  m_*     | out       | slot_out, tickets_out, in_use_out, win_count_out | status
//
// Every command gives one result transfer. Set tickets, set flags and read raise m_tvalid
// after the table read at the transfer edge, a read-modify-write step that forms the
// result, then the output register load. A draw runs 32 steps of the bit-serial modulo
// unit, then a walk that reads one table entry per cycle from slot 0 up to the winning
// slot. A draw with nothing runnable skips the modulo unit and the walk.
// After reset the table memory is cleared one entry per cycle; s_tready stays low during
// that pass. A stalled output holds the sequencer until the output register frees, but a
// new command is taken while the last result still waits.
module lottery_scheduler #(
	parameter int SLOTS = lsch_pkg::DEF_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// slot[5:0], ticket_value[21:6], in_use_value[22], runnable_value[23],
	// random_word[55:24]
	input  logic [lsch_pkg::IN_DATA_W-1:0]   s_tdata,
	// cmd[1:0]
	input  logic [lsch_pkg::IN_USER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// slot_out[5:0], tickets_out[21:6], in_use_out[22], win_count_out[54:23], zero[55]
	output logic [lsch_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status[1:0]
	output logic [lsch_pkg::OUT_USER_W-1:0]  m_tuser
);
	import lsch_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	// The sum of all tickets stays below SLOTS * 2^16.
	localparam int SUM_W = TICK_W + IDX_W;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOTS - 1);

	// Fields of the incoming transfer.
	logic [SLOT_W-1:0] in_slot;
	logic [TICK_W-1:0] in_tickets;
	logic              in_use_in;
	logic              in_run;
	logic [RND_W-1:0]  in_rnd;
	cmd_t              in_cmd;

	assign in_slot    = s_tdata[SLOT_W-1:0];
	assign in_tickets = s_tdata[SLOT_W+TICK_W-1:SLOT_W];
	assign in_use_in  = s_tdata[SLOT_W+TICK_W];
	assign in_run     = s_tdata[SLOT_W+TICK_W+1];
	assign in_rnd     = s_tdata[SLOT_W+TICK_W+2+RND_W-1:SLOT_W+TICK_W+2];
	assign in_cmd     = cmd_t'(s_tuser[CMD_W-1:0]);

	state_t state_q, state_nx;

	// Latched command.
	cmd_t              cmd_q;
	logic [SLOT_W-1:0] slot_q;
	logic [TICK_W-1:0] tv_q;
	logic              iu_q;
	logic              rv_q;
	logic              slot_ok;

	// Running state of the sequencer.
	logic [IDX_W-1:0] clr_addr_q;
	logic [IDX_W-1:0] walk_addr_q;
	logic [IDX_W-1:0] addr_s1;
	logic             rd_vld_s1;
	logic [SUM_W-1:0] sum_q, sum_nx;
	logic [SUM_W-1:0] run_q, run_nx;
	logic             hit;

	// Memory port.
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [IDX_W-1:0] ram_raddr;
	entry_t           ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t           ent_rd, ent_nx;
	logic [TICK_W-1:0] contrib_old;

	// Modulo unit.
	logic             div_start;
	logic [SUM_W-1:0] target;
	div_stat_t        div_stat;

	// Result staging and output register.
	res_t res_q, res_nx;
	res_t out_q;
	logic out_valid_q;
	logic out_load;

	assign slot_ok = (32'(slot_q) < 32'(SLOTS));

	lsch_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lsch_mod #(
		.SUM_W(SUM_W)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(in_rnd),
		.divisor (sum_q),
		.rem     (target),
		.stat    (div_stat)
	);

	assign out_load = (state_q == S_DONE) && (!out_valid_q || m_tready);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_addr_q == IDX_LAST) begin
					state_nx = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					if (in_cmd == CMD_DRAW) begin
						state_nx = (sum_q == '0) ? S_DONE : S_DIV;
					end else begin
						state_nx = S_READ;
					end
				end
			end
			S_READ: state_nx = S_DONE;
			S_DIV: begin
				if (div_stat.done) begin
					state_nx = S_WALK;
				end
			end
			S_WALK: begin
				if (rd_vld_s1 && hit) begin
					state_nx = S_DONE;
				end
			end
			S_DONE: begin
				if (out_load) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// Memory access, sum update and result formation per state.
	always_comb begin
		s_tready    = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = clr_addr_q;
		ram_wdata   = '0;
		ram_raddr   = walk_addr_q;
		div_start   = 1'b0;
		ent_rd      = entry_t'(ram_rdata);
		ent_nx      = ent_rd;
		sum_nx      = sum_q;
		res_nx      = res_q;
		contrib_old = ent_rd.runnable ? ent_rd.tickets : '0;
		run_nx      = run_q + SUM_W'(contrib_old);
		hit         = (run_nx > target);
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				s_tready  = 1'b1;
				ram_raddr = IDX_W'(in_slot);
				div_start = s_tvalid && (in_cmd == CMD_DRAW) && (sum_q != '0);
				// Answer for a draw with no runnable tickets.
				res_nx = '{status: STAT_NONE, slot: '0, tickets: '0, in_use: 1'b0, win: '0};
			end
			S_READ: begin
				case (cmd_q)
					CMD_SET_TICKETS: begin
						if (tv_q != '0) begin
							ent_nx.tickets = tv_q;
							if (ent_rd.runnable) begin
								sum_nx = sum_q - SUM_W'(ent_rd.tickets) + SUM_W'(tv_q);
							end
						end
					end
					CMD_SET_FLAGS: begin
						// A slot newly taken into use starts counting wins from zero.
						if (iu_q && !ent_rd.in_use) begin
							ent_nx.win = '0;
						end
						ent_nx.in_use   = iu_q;
						ent_nx.runnable = rv_q;
						sum_nx = sum_q - SUM_W'(contrib_old)
							+ SUM_W'(rv_q ? ent_rd.tickets : '0);
					end
					default: ;
				endcase
				if (!slot_ok) begin
					sum_nx = sum_q;
				end
				ram_we    = slot_ok && ((cmd_q == CMD_SET_TICKETS) || (cmd_q == CMD_SET_FLAGS));
				ram_waddr = IDX_W'(slot_q);
				ram_wdata = ent_nx;
				res_nx.status  = ((cmd_q == CMD_SET_TICKETS) && (tv_q == '0)) ? STAT_REJECT
					: STAT_OK;
				res_nx.slot    = slot_q;
				res_nx.tickets = slot_ok ? ent_nx.tickets : '0;
				res_nx.in_use  = slot_ok ? ent_nx.in_use : 1'b0;
				res_nx.win     = slot_ok ? ent_nx.win : '0;
			end
			S_WALK: begin
				if (rd_vld_s1 && hit) begin
					ent_nx.win = ent_rd.win + 1'b1;
					ram_we     = 1'b1;
					ram_waddr  = addr_s1;
					ram_wdata  = ent_nx;
					res_nx.status  = STAT_OK;
					res_nx.slot    = SLOT_W'(addr_s1);
					res_nx.tickets = ent_nx.tickets;
					res_nx.in_use  = ent_nx.in_use;
					res_nx.win     = ent_nx.win;
				end
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_addr_q  <= '0;
			walk_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (state_q == S_READ) begin
				sum_q <= sum_nx;
			end
			if (state_q == S_DIV) begin
				walk_addr_q <= '0;
				rd_vld_s1   <= 1'b0;
			end
			if (state_q == S_WALK) begin
				rd_vld_s1   <= 1'b1;
				walk_addr_q <= (walk_addr_q == IDX_LAST) ? '0 : walk_addr_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && s_tvalid) begin
			cmd_q  <= in_cmd;
			slot_q <= in_slot;
			tv_q   <= in_tickets;
			iu_q   <= in_use_in;
			rv_q   <= in_run;
			run_q  <= '0;
			res_q  <= res_nx;
		end
		if (state_q == S_READ) begin
			res_q <= res_nx;
		end
		if (state_q == S_WALK) begin
			addr_s1 <= walk_addr_q;
			if (rd_vld_s1) begin
				run_q <= run_nx;
				if (hit) begin
					res_q <= res_nx;
				end
			end
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_q.win, out_q.in_use, out_q.tickets, out_q.slot};
	assign m_tuser  = out_q.status;

endmodule

// ----- rtl/core/lsch_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module lsch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/core/lsch_mod.sv -----
// Bit-serial restoring modulo unit: remainder of a 32-bit word by a ticket sum.
module lsch_mod #(
	parameter int SUM_W = 22
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [lsch_pkg::RND_W-1:0] dividend,
	input  logic [SUM_W-1:0]          divisor,
	output logic [SUM_W-1:0]          rem,
	output lsch_pkg::div_stat_t       stat
);
	import lsch_pkg::*;

	localparam int CNT_W = $clog2(RND_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RND_W - 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [SUM_W:0]   rem_q;
	logic [RND_W-1:0] dvd_q;
	logic [SUM_W-1:0] dvs_q;
	logic [SUM_W:0]   shifted;
	logic [SUM_W:0]   rem_nx;

	always_comb begin
		shifted = {rem_q[SUM_W-1:0], dvd_q[RND_W-1]};
		if (shifted >= {1'b0, dvs_q}) begin
			rem_nx = shifted - {1'b0, dvs_q};
		end else begin
			rem_nx = shifted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
		end
	end

	assign rem       = rem_q[SUM_W-1:0];
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- rtl/core/lsch_checker.sv -----
// Port-level checks of the lottery scheduler, bound to its top level.
module lsch_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [lsch_pkg::IN_DATA_W-1:0]   s_tdata,
	input logic [lsch_pkg::IN_USER_W-1:0]   s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [lsch_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [lsch_pkg::OUT_USER_W-1:0]  m_tuser
);
	import lsch_pkg::*;

	// A stalled result keeps its content.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Commands are worked one at a time: no transfer in the cycle after one.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken while another is in progress");

	// Only the three defined status codes appear.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK) || (m_tuser == STAT_REJECT) || (m_tuser == STAT_NONE))
		else $error("undefined status code");

	// An empty draw reports an all-zero entry.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == STAT_NONE) |-> (m_tdata == '0))
		else $error("empty draw with nonzero fields");

	// The padding bit of the result stays clear.
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[OUT_DATA_W-1])
		else $error("result padding bit set");

endmodule

bind lottery_scheduler lsch_checker u_lsch_checker (.*);
